// ----- rtl/lia_pkg.sv -----
package lia_pkg;

    // geometry register width and result width are fixed by the interface
    localparam int CFG_W        = 7;
    localparam int AREA_OUT_W   = 13;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam logic [CFG_W-1:0] RESET_GEOM = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_ROW = 1'b0;
    localparam logic REG_COL = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_POP,
        ST_POP_WAIT,
        ST_NBR,
        ST_DONE
    } lia_state_t;

    // effective (clamped) grid geometry
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } geom_t;

endpackage

// ----- rtl/lia_core.sv -----
module lia_core #(
    parameter int MAX_ROWS = lia_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lia_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lia_pkg::geom_t                 geom,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cell_bit,
    input  logic                           last_cell,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lia_pkg::AREA_OUT_W-1:0] island_area
);
    import lia_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int TOT_W = 2 * CFG_W;
    localparam int AW    = ((CNT_W > TOT_W) ? CNT_W : TOT_W) + 1;

    // stack word: linear cell index plus its column, so no divide is needed
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] col;
    } stk_t;

    lia_state_t state_reg, state_next;

    logic [CNT_W-1:0] load_pos_reg, load_pos_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CFG_W-1:0] scol_reg, scol_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] region_reg, region_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic [2:0]       k_reg, k_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pq_reg, pq_next;
    logic [CFG_W-1:0] pc_reg, pc_next;
    logic             out_valid_reg, out_valid_next;
    logic [AREA_OUT_W-1:0] area_reg, area_next;

    logic             land_mem [CELLS];
    logic             land_rd_reg;
    logic             land_we;
    logic             land_wd;
    logic [IDX_W-1:0] land_wa;
    logic [IDX_W-1:0] land_ra;

    stk_t             stk_mem [CELLS];
    stk_t             stk_rd_reg;
    logic             stk_we;
    logic             stk_re;
    stk_t             stk_wd;
    logic [IDX_W-1:0] stk_wa;
    logic [IDX_W-1:0] stk_ra;

    logic [AW-1:0]    total_a;
    logic [AW-1:0]    cols_a;
    logic [AW-1:0]    fill_a;
    logic [AW-1:0]    scan_a;
    logic [AW-1:0]    p_a;
    logic [AW-1:0]    nb_q;
    logic [CFG_W-1:0] nb_col;
    logic             nb_in;
    logic [CNT_W-1:0] depth_dec;
    logic [CFG_W-1:0] scol_inc;
    logic             hit;

    assign total_a   = AW'(geom.rows) * AW'(geom.cols);
    assign cols_a    = AW'(geom.cols);
    assign fill_a    = AW'(load_pos_reg);
    assign scan_a    = AW'(scan_reg);
    assign p_a       = AW'(stk_rd_reg.idx);
    assign depth_dec = depth_reg - 1'b1;
    assign scol_inc  = (AW'(scol_reg) + 1'b1 == cols_a) ? '0 : scol_reg + 1'b1;
    assign hit       = pend_reg && land_rd_reg;

    // neighbor k of the popped cell: up, down, right, left
    always_comb
    begin
        nb_q   = p_a;
        nb_col = stk_rd_reg.col;
        nb_in  = 1'b0;
        case (k_reg)
            3'd0:
            begin
                nb_q  = p_a - cols_a;
                nb_in = (p_a >= cols_a);
            end
            3'd1:
            begin
                nb_q  = p_a + cols_a;
                nb_in = (nb_q < total_a);
            end
            3'd2:
            begin
                nb_q   = p_a + 1'b1;
                nb_col = stk_rd_reg.col + 1'b1;
                nb_in  = (AW'(stk_rd_reg.col) + 1'b1 < cols_a);
            end
            3'd3:
            begin
                nb_q   = p_a - 1'b1;
                nb_col = stk_rd_reg.col - 1'b1;
                nb_in  = (stk_rd_reg.col != '0);
            end
            default:
            begin
                nb_in = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        load_pos_next  = load_pos_reg;
        scan_next      = scan_reg;
        scol_next      = scol_reg;
        depth_next     = depth_reg;
        region_next    = region_reg;
        best_next      = best_reg;
        k_next         = k_reg;
        pend_next      = pend_reg;
        pq_next        = pq_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        area_next      = area_reg;

        land_we = 1'b0;
        land_wa = load_pos_reg[IDX_W-1:0];
        land_wd = cell_bit;
        land_ra = scan_reg[IDX_W-1:0];

        stk_we     = 1'b0;
        stk_re     = 1'b0;
        stk_wa     = depth_reg[IDX_W-1:0];
        stk_wd.idx = pq_reg;
        stk_wd.col = pc_reg;
        stk_ra     = depth_dec[IDX_W-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (AW'(load_pos_reg) < total_a)
                    begin
                        land_we       = 1'b1;
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                    if (last_cell)
                    begin
                        scan_next  = '0;
                        scol_next  = '0;
                        best_next  = '0;
                        state_next = ST_SCAN_RD;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                if (scan_a < total_a)
                begin
                    pend_next  = (scan_a < fill_a);
                    state_next = ST_SCAN_CHK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_SCAN_CHK:
            begin
                if (hit)
                begin
                    // seed a new region
                    land_we     = 1'b1;
                    land_wa     = scan_reg[IDX_W-1:0];
                    land_wd     = 1'b0;
                    stk_we      = 1'b1;
                    stk_wa      = '0;
                    stk_wd.idx  = scan_reg[IDX_W-1:0];
                    stk_wd.col  = scol_reg;
                    depth_next  = CNT_W'(1);
                    region_next = CNT_W'(1);
                    state_next  = ST_POP;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    scol_next  = scol_inc;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_POP:
            begin
                if (depth_reg == '0)
                begin
                    if (region_reg > best_reg)
                    begin
                        best_next = region_reg;
                    end
                    scan_next  = scan_reg + 1'b1;
                    scol_next  = scol_inc;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    // popped word stays in stk_rd_reg for the whole probe run
                    stk_re     = 1'b1;
                    depth_next = depth_dec;
                    state_next = ST_POP_WAIT;
                end
            end

            ST_POP_WAIT:
            begin
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_NBR;
            end

            ST_NBR:
            begin
                // retire the probe issued last cycle
                if (hit)
                begin
                    land_we = 1'b1;
                    land_wa = pq_reg;
                    land_wd = 1'b0;
                    if (depth_reg < CNT_W'(CELLS))
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                    region_next = region_reg + 1'b1;
                end
                // issue the next probe
                if (k_reg < 3'd4)
                begin
                    land_ra   = nb_q[IDX_W-1:0];
                    pend_next = nb_in && (nb_q < fill_a);
                    pq_next   = nb_q[IDX_W-1:0];
                    pc_next   = nb_col;
                    k_next    = k_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_POP;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    area_next      = AREA_OUT_W'(best_reg);
                    load_pos_next  = '0;
                    state_next     = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_pos_reg  <= '0;
            scan_reg      <= '0;
            scol_reg      <= '0;
            depth_reg     <= '0;
            region_reg    <= '0;
            best_reg      <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            scan_reg      <= scan_next;
            scol_reg      <= scol_next;
            depth_reg     <= depth_next;
            region_reg    <= region_next;
            best_reg      <= best_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pq_reg   <= pq_next;
        pc_reg   <= pc_next;
        area_reg <= area_next;
    end

    // grid store
    always_ff @(posedge clk)
    begin
        if (land_we)
        begin
            land_mem[land_wa] <= land_wd;
        end
        land_rd_reg <= land_mem[land_ra];
    end

    // visit stack
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_ra];
        end
    end

    assign in_stall    = (state_reg != ST_LOAD);
    assign out_valid   = out_valid_reg;
    assign island_area = area_reg;

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NBR && hit) |=> region_reg == $past(region_reg) + 1'b1)
        else $error("region size not bumped on push");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_scan_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD) |-> depth_reg == '0)
        else $error("stack not empty while scanning");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && in_valid) |=> load_pos_reg <= CNT_W'(CELLS))
        else $error("load position past grid store");

endmodule

// ----- rtl/largest_island_area.sv -----
// Largest 4-connected land region of a binary grid.
// Load: one cell beat per cycle; in_stall stays low until the last cell.
// Flood: after the last cell, each grid cell is scanned (read, check), each land cell
//   gets a stack pop, stack read and four neighbor probes, each region a best update;
//   the result waits while an earlier one is stalled; one grid is in flight at a time.
// Reset: control and counters cleared, rows_reg/cols_reg at 64; no clearing pass.
module largest_island_area #(
    parameter int MAX_ROWS = lia_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lia_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lia_pkg::ADDR_W-1:0]     paddr,
    input  logic [lia_pkg::DATA_W-1:0]     pwdata,
    output logic [lia_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // cell input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cell_bit,
    input  logic                           last_cell,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lia_pkg::AREA_OUT_W-1:0] island_area
);
    import lia_pkg::*;

    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic             reg_sel;
    logic             wr_en;
    geom_t            geom;

    // register index is the word address; low byte-offset bits are ignored
    assign reg_sel = paddr[ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ROW: rows_next = pwdata[CFG_W-1:0];
                REG_COL: cols_next = pwdata[CFG_W-1:0];
                default: rows_next = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= RESET_GEOM;
            cols_reg <= RESET_GEOM;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROW: prdata = DATA_W'(rows_reg);
            REG_COL: prdata = DATA_W'(cols_reg);
            default: prdata = '0;
        endcase
    end

    // clamp geometry into 1..MAX; zero acts as one
    always_comb
    begin
        if (rows_reg == '0)
        begin
            geom.rows = CFG_W'(1);
        end
        else if (32'(rows_reg) > MAX_ROWS)
        begin
            geom.rows = CFG_W'(MAX_ROWS);
        end
        else
        begin
            geom.rows = rows_reg;
        end

        if (cols_reg == '0)
        begin
            geom.cols = CFG_W'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            geom.cols = CFG_W'(MAX_COLS);
        end
        else
        begin
            geom.cols = cols_reg;
        end
    end

    // load, scan and flood sequencer with the grid store and visit stack
    lia_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_bit    (cell_bit),
        .last_cell   (last_cell),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .island_area (island_area)
    );

endmodule

// ----- verif/largest_island_area_checker.sv -----
`timescale 1ns / 100ps

// Watches the register port and both beat channels, keeps a shadow copy of
// the geometry and the grid, and checks every island_area beat in order.
module largest_island_area_checker #(
    parameter int MAX_ROWS = lia_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lia_pkg::DEF_MAX_COLS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lia_pkg::ADDR_W-1:0]     paddr,
    input  logic [lia_pkg::DATA_W-1:0]     pwdata,
    input  logic [lia_pkg::DATA_W-1:0]     prdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           cell_bit,
    input  logic                           last_cell,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lia_pkg::AREA_OUT_W-1:0] island_area,
    output int                             fail_count,
    output int                             pending_count,
    output int                             area_count
);
    import lia_pkg::*;

    localparam int CELLS = MAX_ROWS * MAX_COLS;

    logic [CFG_W-1:0]      rows_reg;
    logic [CFG_W-1:0]      cols_reg;
    bit                    land_grid [CELLS];
    int unsigned           fill_pos;
    logic [AREA_OUT_W-1:0] area_fifo [$];

    initial
    begin
        fail_count    = 0;
        area_count    = 0;
        pending_count = 0;
    end

    task automatic flag_error(input string what, input logic [DATA_W-1:0] got,
                              input logic [DATA_W-1:0] want);
        $display("ERROR %0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // out-of-range register values clamp to the legal span
    function automatic int unsigned dim_used(input logic [CFG_W-1:0] raw,
                                             input int unsigned limit);
        if (raw < 1)
            return 1;
        if (raw > limit)
            return limit;
        return 32'(raw);
    endfunction

    function automatic int unsigned grid_total();
        return dim_used(rows_reg, MAX_ROWS) * dim_used(cols_reg, MAX_COLS);
    endfunction

    // flood every land region with an explicit stack; cells are cleared when pushed
    function automatic logic [AREA_OUT_W-1:0] largest_region();
        int unsigned cols;
        int unsigned total;
        int unsigned depth;
        int unsigned size;
        int unsigned best;
        int unsigned s;
        int unsigned p;
        int unsigned q;
        int          k;
        bit          ok;
        int unsigned stk [CELLS];
        cols  = dim_used(cols_reg, MAX_COLS);
        total = grid_total();
        best  = 0;
        for (s = 0; s < total; s++)
        begin
            if (land_grid[s])
            begin
                land_grid[s] = 1'b0;
                stk[0]       = s;
                depth        = 1;
                size         = 1;
                while (depth > 0)
                begin
                    depth--;
                    p = stk[depth];
                    for (k = 0; k < 4; k++)
                    begin
                        case (k)
                            0:
                            begin
                                ok = (p >= cols);
                                q  = p - cols;
                            end
                            1:
                            begin
                                ok = 1'b1;
                                q  = p + cols;
                            end
                            2:
                            begin
                                ok = ((p % cols) + 1 < cols);
                                q  = p + 1;
                            end
                            default:
                            begin
                                ok = ((p % cols) > 0);
                                q  = p - 1;
                            end
                        endcase
                        if (ok && q < total && land_grid[q])
                        begin
                            land_grid[q] = 1'b0;
                            stk[depth]   = q;
                            depth++;
                            size++;
                        end
                    end
                end
                if (size > best)
                    best = size;
            end
        end
        return best[AREA_OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [AREA_OUT_W-1:0] want;
        logic [CFG_W-1:0]      reg_val;
        if (!rst_n)
        begin
            rows_reg = RESET_GEOM;
            cols_reg = RESET_GEOM;
            fill_pos = 0;
            foreach (land_grid[i])
                land_grid[i] = 1'b0;
            area_fifo.delete();
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_val = (paddr[ADDR_W-1] == REG_ROW) ? rows_reg : cols_reg;
                if (pwrite)
                begin
                    if (paddr[ADDR_W-1] == REG_ROW)
                        rows_reg = pwdata[CFG_W-1:0];
                    else
                        cols_reg = pwdata[CFG_W-1:0];
                end
                else if (prdata !== {{(DATA_W-CFG_W){1'b0}}, reg_val})
                    flag_error("register readback", prdata, DATA_W'(reg_val));
            end

            if (in_valid && !in_stall)
            begin
                // cells past the grid are dropped, but last_cell still counts
                if (fill_pos < grid_total())
                begin
                    land_grid[fill_pos] = cell_bit;
                    fill_pos++;
                end
                if (last_cell)
                begin
                    area_fifo.push_back(largest_region());
                    foreach (land_grid[i])
                        land_grid[i] = 1'b0;
                    fill_pos = 0;
                end
            end

            if (out_valid && !out_stall)
            begin
                if (area_fifo.size() == 0)
                    flag_error("island_area beat with nothing pending",
                               DATA_W'(island_area), '0);
                else
                begin
                    want = area_fifo.pop_front();
                    area_count++;
                    if (island_area !== want)
                        flag_error("island_area", DATA_W'(island_area), DATA_W'(want));
                end
            end
        end
        pending_count = area_fifo.size();
    end

endmodule

// ----- verif/largest_island_area_tb.sv -----
`timescale 1ns / 100ps

// Stimulus side of the island-area bench. The checker instance does all of the
// prediction; this module only drives beats, register accesses and back-pressure,
// and turns the checker's failure count into the verdict.
module largest_island_area_tb;
    import lia_pkg::*;

    localparam int          DIM_MAX      = 64;
    localparam int unsigned RUN_LIMIT    = 1000000;  // cycles; far above a slow pass
    localparam int          RANDOM_CELLS = 1100;
    localparam int          HOLD_LEN     = 400;      // long receiver hold-off
    localparam int          SETTLE       = 16;       // quiet cycles before a register write
    localparam int          DRAIN_WAIT   = 64;

    localparam logic [ADDR_W-1:0] ROW_ADDR = {REG_ROW, 2'b00};
    localparam logic [ADDR_W-1:0] COL_ADDR = {REG_COL, 2'b00};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic                  cell_bit;
    logic                  last_cell;
    logic                  out_valid;
    logic                  out_stall;
    logic [AREA_OUT_W-1:0] island_area;

    int                    fail_count;
    int                    pending_count;
    int                    area_count;

    // idle knobs for the sender and for the receiver process
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int                    hold_token;

    // geometry as last written, used only to size the loads
    logic [CFG_W-1:0]      rows_raw;
    logic [CFG_W-1:0]      cols_raw;

    int                    loads_sent;
    int                    cells_sent;
    int unsigned           cycles;

    largest_island_area uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cell_bit    (cell_bit),
        .last_cell   (last_cell),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .island_area (island_area)
    );

    largest_island_area_checker area_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cell_bit      (cell_bit),
        .last_cell     (last_cell),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .island_area   (island_area),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .area_count    (area_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Watchdog: a hung flood or a lost beat ends up here.
    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("largest_island_area test failed");
        $finish;
    end

    // Receiver: random stall per cycle, plus a long hold-off each time the
    // stimulus bumps hold_token. The hold is counted here, not in the sender.
    initial
    begin
        int seen;
        int left;
        seen = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_token != seen)
            begin
                seen = hold_token;
                left = HOLD_LEN;
            end
            if (left > 0)
            begin
                left--;
                out_stall = 1'b1;
            end
            else
                out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic int unsigned dim_used(input logic [CFG_W-1:0] raw);
        if (raw < 1)
            return 1;
        if (raw > DIM_MAX)
            return DIM_MAX;
        return 32'(raw);
    endfunction

    function automatic int unsigned grid_cells();
        return dim_used(rows_raw) * dim_used(cols_raw);
    endfunction

    // One APB transfer: setup cycle, then access until pready. Called at negedge.
    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Wait for the pipeline to drain, then write one register (random upper
    // data bits, which the block must ignore) and read it back.
    task automatic retune(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        logic [DATA_W-1:0] data;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        data             = $urandom();
        data[CFG_W-1:0]  = value;
        apb_access(1'b1, addr, data);
        if (addr == ROW_ADDR)
            rows_raw = value;
        else
            cols_raw = value;
        apb_access(1'b0, addr, $urandom());
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        retune(ROW_ADDR, rows);
        retune(COL_ADDR, cols);
    endtask

    // One cell beat. Optional idle gap first; valid then holds until accepted.
    task automatic push_cell(input logic land, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid  = 1'b1;
        cell_bit  = land;
        last_cell = fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid  = 1'b0;
        // junk on the payload while idle; it must be ignored
        cell_bit  = 1'($urandom_range(1));
        last_cell = 1'($urandom_range(1));
        cells_sent++;
        if (fin)
            loads_sent++;
    endtask

    // pattern bit 0 goes first; the final beat carries last_cell
    task automatic send_pattern(input logic [63:0] pattern, input int len);
        int i;
        for (i = 0; i < len; i++)
            push_cell(pattern[i], i == len - 1);
    endtask

    task automatic send_random(input int count, input int unsigned land_pct);
        int i;
        for (i = 0; i < count; i++)
            push_cell($urandom_range(99) < land_pct, i == count - 1);
    endtask

    // small: 0..6 (0 clamps to 1); big: exactly 64 or an over-range value
    function automatic logic [CFG_W-1:0] small_dim();
        return CFG_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [CFG_W-1:0] big_dim();
        return $urandom_range(1) ? CFG_W'(DIM_MAX)
                                 : CFG_W'($urandom_range(DIM_MAX + 1, 127));
    endfunction

    // Mostly small grids; tall and wide strips at the 64 limit; rarely the
    // full 64x64 array (those get short loads only, see load sizing below).
    task automatic pick_geometry();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            set_geometry(small_dim(), small_dim());
        else if (r < 75)
            set_geometry(big_dim(), CFG_W'($urandom_range(0, 2)));
        else if (r < 90)
            set_geometry(CFG_W'($urandom_range(0, 2)), big_dim());
        else if (r < 95)
            set_geometry(big_dim(), big_dim());
        else
            set_geometry(CFG_W'($urandom_range(1)), CFG_W'($urandom_range(1)));
    endtask

    initial
    begin
        int          mode;
        int          grids;
        int          quota;
        int          count;
        int unsigned total;
        int unsigned r;
        int unsigned land_pct;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        cell_bit       = 1'b0;
        last_cell      = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_token     = 0;
        rows_raw       = RESET_GEOM;
        cols_raw       = RESET_GEOM;
        loads_sent     = 0;
        cells_sent     = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---------------- directed ----------------
        // reset geometry is 64x64; check the readback before touching it
        apb_access(1'b0, ROW_ADDR, '0);
        apb_access(1'b0, COL_ADDR, '0);

        // short loads into the full array: lone land cell, then no land at all
        send_pattern(64'h1, 1);
        send_pattern(64'h0, 1);

        // zero rows clamps to one, 127 cols clamps to 64: a single 64-cell row
        set_geometry(7'd0, 7'd127);
        send_pattern(64'b011, 3);

        // 1x1 grid: extra beats are dropped, last_cell on a dropped beat ends the load
        set_geometry(7'd1, 7'd1);
        send_pattern(64'b101, 3);

        // 3x3: land at the end of one row and start of the next must not join
        set_geometry(7'd3, 7'd3);
        send_pattern(64'h10C, 9);

        // geometry change mid-load: 2x2 becomes 2x1, the two stored cells
        // turn into a vertical pair and the final beat no longer fits
        set_geometry(7'd2, 7'd2);
        push_cell(1'b1, 1'b0);
        push_cell(1'b1, 1'b0);
        retune(COL_ADDR, 7'd1);
        push_cell(1'b1, 1'b1);

        // mid-load shrink leaves a stored land cell outside the grid: ignored
        set_geometry(7'd2, 7'd2);
        push_cell(1'b0, 1'b0);
        push_cell(1'b0, 1'b0);
        push_cell(1'b1, 1'b0);
        retune(COL_ADDR, 7'd1);
        push_cell(1'b0, 1'b1);

        // that stray cell must be gone: a stale copy would join cell 0
        set_geometry(7'd2, 7'd2);
        send_pattern(64'b01, 2);

        // ---------------- random ----------------
        // mode 0: no idling, 1: sender idle 75%, 2: receiver stalls 75%, 3: both 15%
        for (mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 15;
                end
            endcase
            quota = cells_sent + RANDOM_CELLS / 4;
            grids = 0;
            while (cells_sent < quota || grids < 16)
            begin
                if (grids % 4 == 0)
                    pick_geometry();

                // receiver holds off while the sender keeps loading grids,
                // so a finished area backs up and the cell channel stalls
                if (mode == 0 && grids == 5)
                    hold_token++;

                // sender goes quiet until every area is back
                if (mode == 1 && grids == 6)
                    while (pending_count != 0)
                        @(negedge clk);

                total = grid_cells();
                r     = $urandom_range(99);
                if (total > 256 || (r >= 70 && r < 85))
                    count = $urandom_range(1, (total > 40) ? 40 : total);
                else if (r >= 85)
                    count = total + $urandom_range(1, 4);
                else
                    count = total;

                case ($urandom_range(4))
                    0:       land_pct = 0;
                    1:       land_pct = 100;
                    2:       land_pct = 30;
                    3:       land_pct = 55;
                    default: land_pct = 80;
                endcase
                send_random(count, land_pct);
                grids++;
            end
        end

        // ---------------- wrap-up ----------------
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("covered %0d grid loads, %0d cell beats, %0d areas compared",
                 loads_sent, cells_sent, area_count);
        $display("geometry 1x1 to 64x64 incl. clamped values, mid-load changes, 4 idle mixes");
        if (fail_count == 0)
            $display("largest_island_area test passed");
        else
            $display("largest_island_area test failed");
        $finish;
    end

endmodule

// ----- largest_island_area.f -----
rtl/lia_pkg.sv
rtl/lia_core.sv
rtl/largest_island_area.sv
verif/largest_island_area_checker.sv
verif/largest_island_area_tb.sv
